// File: rtl/core/qlu_pkg.sv
`default_nettype none

package qlu_pkg;

   typedef enum logic [2:0] {
      MODE_SKIP = 3'd0,
      MODE_BODY = 3'd1,
      MODE_ESC  = 3'd2,
      MODE_HEX  = 3'd3,
      MODE_DONE = 3'd4
   } mode_type;

   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_OK   = 2'd1;
   localparam logic [1:0] KIND_BAD  = 2'd2;

   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5c;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB = 8'h09;

   localparam logic [31:0] CP_MAX1 = 32'h7f;
   localparam logic [31:0] CP_MAX2 = 32'h7ff;
   localparam logic [31:0] CP_MAX3 = 32'hffff;
   localparam logic [31:0] CP_MAX4 = 32'h10ffff;
   localparam logic [7:0] LEAD2 = 8'hc0;
   localparam logic [7:0] LEAD3 = 8'he0;
   localparam logic [7:0] LEAD4 = 8'hf0;
   localparam logic [7:0] CONT = 8'h80;
   localparam logic [5:0] CONT_MASK = 6'h3f;

   // Work for the back end that one request produces: up to four data
   // bytes followed by an optional status result.
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      nbytes;
      logic            has_status;
      logic [1:0]      status;
   } job_type;

endpackage

`default_nettype wire

// File: rtl/core/quoted_literal_unescape_utf8.sv
// Path: a request's results are written into the queue when the request is taken, then
// loaded into the back-end job register once it is free, and only then offered.
// Throughput: one request per cycle while each request yields at most one result and
// the output is not stalled; results beyond that wait in the two-entry queue between
// parser and output, which absorbs the difference before the input stalls.
// Reset is synchronous and active high; it empties the queue and returns the parser
// to the state before the opening quote.
`default_nettype none

module quoted_literal_unescape_utf8 (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] in_byte
   input  wire logic       req_tlast,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] out_byte
   output logic [1:0]      rsp_tuser,   // [1:0] out_kind
   output logic            rsp_tlast
);

   qlu_pkg::job_type push_job, head_job;
   logic push, pop, has_space, not_empty, accept;

   assign req_tready = has_space;
   assign accept = req_tvalid && has_space;

   qlu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .in_byte  (req_tdata),
      .line_end (req_tlast),
      .job      (push_job),
      .job_push (push)
   );

   qlu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .has_space (has_space),
      .pop       (pop),
      .not_empty (not_empty),
      .head_job  (head_job)
   );

   qlu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (not_empty),
      .job        (head_job),
      .job_pop    (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// File: rtl/core/qlu_front.sv
`default_nettype none

module qlu_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic [7:0]       in_byte,
   input  wire logic             line_end,
   output qlu_pkg::job_type      job,
   output logic                  job_push
);

   qlu_pkg::mode_type mode_ff, mode_in;
   logic [3:0]  hex_ff, hex_in;
   logic [31:0] acc_ff, acc_in;
   logic [3:0]  nib;
   logic        nib_ok;
   logic [31:0] acc_shift;
   logic [3:0]  hex_dec;
   qlu_pkg::job_type j;

   always_comb begin
      nib = 4'd0;
      nib_ok = 1'b1;
      if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
         nib = 4'(in_byte - 8'h30);
      end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
         nib = 4'(in_byte - 8'h57);
      end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
         nib = 4'(in_byte - 8'h37);
      end else begin
         nib_ok = 1'b0;
      end
   end

   assign acc_shift = {acc_ff[27:0], nib};
   assign hex_dec = hex_ff - 4'd1;

   always_comb begin
      mode_in = mode_ff;
      hex_in = hex_ff;
      acc_in = acc_ff;
      j = '0;
      unique case (mode_ff)
         qlu_pkg::MODE_SKIP: begin
            if (in_byte == qlu_pkg::CHAR_QUOTE) begin
               mode_in = qlu_pkg::MODE_BODY;
            end else if (in_byte != qlu_pkg::CHAR_SPACE && in_byte != qlu_pkg::CHAR_TAB) begin
               j.has_status = 1'b1;
               j.status = qlu_pkg::KIND_BAD;
               mode_in = qlu_pkg::MODE_DONE;
            end
         end
         qlu_pkg::MODE_BODY: begin
            if (in_byte == qlu_pkg::CHAR_QUOTE) begin
               j.has_status = 1'b1;
               j.status = qlu_pkg::KIND_OK;
               mode_in = qlu_pkg::MODE_DONE;
            end else if (in_byte == qlu_pkg::CHAR_BSLASH) begin
               mode_in = qlu_pkg::MODE_ESC;
            end else begin
               j.bytes[0] = in_byte;
               j.nbytes = 3'd1;
            end
         end
         qlu_pkg::MODE_ESC: begin
            mode_in = qlu_pkg::MODE_BODY;
            j.nbytes = 3'd1;
            unique case (in_byte)
               8'h74: j.bytes[0] = 8'h09;
               8'h62: j.bytes[0] = 8'h08;
               8'h6e: j.bytes[0] = 8'h0a;
               8'h72: j.bytes[0] = 8'h0d;
               8'h66: j.bytes[0] = 8'h0c;
               8'h75, 8'h55: begin
                  j.nbytes = 3'd0;
                  hex_in = (in_byte == 8'h75) ? 4'd4 : 4'd8;
                  acc_in = 32'd0;
                  mode_in = qlu_pkg::MODE_HEX;
               end
               default: j.bytes[0] = in_byte;
            endcase
         end
         qlu_pkg::MODE_HEX: begin
            if (!nib_ok) begin
               j.has_status = 1'b1;
               j.status = qlu_pkg::KIND_BAD;
               mode_in = qlu_pkg::MODE_DONE;
            end else begin
               acc_in = acc_shift;
               hex_in = hex_dec;
               if (hex_dec == 4'd0) begin
                  mode_in = qlu_pkg::MODE_BODY;
                  if (acc_shift <= qlu_pkg::CP_MAX1) begin
                     j.bytes[0] = acc_shift[7:0];
                     j.nbytes = 3'd1;
                  end else if (acc_shift <= qlu_pkg::CP_MAX2) begin
                     j.bytes[0] = qlu_pkg::LEAD2 | {3'd0, acc_shift[10:6]};
                     j.bytes[1] = qlu_pkg::CONT | {2'd0, acc_shift[5:0] & qlu_pkg::CONT_MASK};
                     j.nbytes = 3'd2;
                  end else if (acc_shift <= qlu_pkg::CP_MAX3) begin
                     j.bytes[0] = qlu_pkg::LEAD3 | {4'd0, acc_shift[15:12]};
                     j.bytes[1] = qlu_pkg::CONT | {2'd0, acc_shift[11:6]};
                     j.bytes[2] = qlu_pkg::CONT | {2'd0, acc_shift[5:0]};
                     j.nbytes = 3'd3;
                  end else if (acc_shift <= qlu_pkg::CP_MAX4) begin
                     j.bytes[0] = qlu_pkg::LEAD4 | {5'd0, acc_shift[20:18]};
                     j.bytes[1] = qlu_pkg::CONT | {2'd0, acc_shift[17:12]};
                     j.bytes[2] = qlu_pkg::CONT | {2'd0, acc_shift[11:6]};
                     j.bytes[3] = qlu_pkg::CONT | {2'd0, acc_shift[5:0]};
                     j.nbytes = 3'd4;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      if (line_end) begin
         if (mode_in != qlu_pkg::MODE_DONE) begin
            j.has_status = 1'b1;
            j.status = qlu_pkg::KIND_BAD;
         end
         mode_in = qlu_pkg::MODE_SKIP;
         hex_in = 4'd0;
         acc_in = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= qlu_pkg::MODE_SKIP;
         hex_ff <= 4'd0;
         acc_ff <= 32'd0;
      end else if (accept) begin
         mode_ff <= mode_in;
         hex_ff <= hex_in;
         acc_ff <= acc_in;
      end
   end

   assign job = j;
   assign job_push = accept && (j.has_status || j.nbytes != 3'd0);

endmodule

`default_nettype wire

// File: rtl/core/qlu_queue.sv
`default_nettype none

module qlu_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire qlu_pkg::job_type push_job,
   output logic                  has_space,
   input  wire logic             pop,
   output logic                  not_empty,
   output qlu_pkg::job_type      head_job
);

   qlu_pkg::job_type slot_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ff <= ~wr_ff;
         end
         if (pop) begin
            rd_ff <= ~rd_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   assign has_space = count_ff != 2'd2;
   assign not_empty = count_ff != 2'd0;
   assign head_job = slot_ff[rd_ff];

endmodule

`default_nettype wire

// File: rtl/core/qlu_back.sv
`default_nettype none

module qlu_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             job_valid,
   input  wire qlu_pkg::job_type job,
   output logic                  job_pop,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [7:0]            rsp_tdata,
   output logic [1:0]            rsp_tuser,
   output logic                  rsp_tlast
);

   qlu_pkg::job_type job_ff;
   logic       busy_ff;
   logic [2:0] idx_ff;
   logic [2:0] total;
   logic       done;
   logic       load;

   assign total = job_ff.nbytes + {2'd0, job_ff.has_status};
   assign rsp_tlast = idx_ff == total - 3'd1;
   assign done = busy_ff && rsp_tready && rsp_tlast;
   assign load = job_valid && (!busy_ff || done);
   assign job_pop = load;
   assign rsp_tvalid = busy_ff;

   always_comb begin
      if (idx_ff < job_ff.nbytes) begin
         rsp_tdata = job_ff.bytes[idx_ff[1:0]];
         rsp_tuser = qlu_pkg::KIND_BYTE;
      end else begin
         rsp_tdata = 8'd0;
         rsp_tuser = job_ff.status;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         job_ff <= job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff <= 3'd0;
      end else if (load) begin
         busy_ff <= 1'b1;
         idx_ff <= 3'd0;
      end else if (done) begin
         busy_ff <= 1'b0;
         idx_ff <= 3'd0;
      end else if (busy_ff && rsp_tready) begin
         idx_ff <= idx_ff + 3'd1;
      end
   end

endmodule

`default_nettype wire

// File: sim/tb_quoted_literal_unescape_utf8.sv
`timescale 1ns / 1ps

module tb_quoted_literal_unescape_utf8;

   typedef struct {
      logic [7:0] data;
      logic [1:0] kind;
      logic       last;
   } lit_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] in_byte
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] out_byte
   logic [1:0] rsp_tuser;           // [1:0] out_kind
   logic       rsp_tlast;

   qlu_pkg::mode_type lit_mode = qlu_pkg::MODE_SKIP;
   logic [3:0]  digits_left = 4'd0;
   logic [31:0] cp_acc = 32'd0;

   lit_result_type decoded_results[$];
   lit_result_type step_results[$];
   logic [7:0]  line_bytes[$];

   int error_count = 0;
   int lines_sent = 0;
   int bytes_taken = 0;
   int results_checked = 0;
   int random_items = 0;
   int burst_left = 0;
   logic [6:0] stall_phase = 7'd0;
   logic [1:0] stall_style = 2'd0;

   quoted_literal_unescape_utf8 dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   function automatic int hex_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
   endfunction

   function void add_result(logic [7:0] data, logic [1:0] kind);
      lit_result_type r;
      r.data = data;
      r.kind = kind;
      r.last = 1'b0;
      step_results.insert(step_results.size(), r);
   endfunction

   function void add_utf8(logic [31:0] cp);
      if (cp <= qlu_pkg::CP_MAX1) begin
         add_result(cp[7:0], qlu_pkg::KIND_BYTE);
      end else if (cp <= qlu_pkg::CP_MAX2) begin
         add_result(qlu_pkg::LEAD2 | {3'b0, cp[10:6]}, qlu_pkg::KIND_BYTE);
         add_result(qlu_pkg::CONT | {2'b0, cp[5:0]}, qlu_pkg::KIND_BYTE);
      end else if (cp <= qlu_pkg::CP_MAX3) begin
         add_result(qlu_pkg::LEAD3 | {4'b0, cp[15:12]}, qlu_pkg::KIND_BYTE);
         add_result(qlu_pkg::CONT | {2'b0, cp[11:6]}, qlu_pkg::KIND_BYTE);
         add_result(qlu_pkg::CONT | {2'b0, cp[5:0]}, qlu_pkg::KIND_BYTE);
      end else if (cp <= qlu_pkg::CP_MAX4) begin
         add_result(qlu_pkg::LEAD4 | {5'b0, cp[20:18]}, qlu_pkg::KIND_BYTE);
         add_result(qlu_pkg::CONT | {2'b0, cp[17:12]}, qlu_pkg::KIND_BYTE);
         add_result(qlu_pkg::CONT | {2'b0, cp[11:6]}, qlu_pkg::KIND_BYTE);
         add_result(qlu_pkg::CONT | {2'b0, cp[5:0]}, qlu_pkg::KIND_BYTE);
      end
   endfunction

   // Advances the expected parser state by one request byte and queues the
   // results that byte should produce.
   function void predict_decode(logic [7:0] c, logic line_end);
      int h;
      h = hex_value(c);
      step_results.delete();
      case (lit_mode)
         qlu_pkg::MODE_SKIP: begin
            if (c == qlu_pkg::CHAR_QUOTE) begin
               lit_mode = qlu_pkg::MODE_BODY;
            end else if (c != qlu_pkg::CHAR_SPACE && c != qlu_pkg::CHAR_TAB) begin
               add_result(8'h00, qlu_pkg::KIND_BAD);
               lit_mode = qlu_pkg::MODE_DONE;
            end
         end
         qlu_pkg::MODE_BODY: begin
            if (c == qlu_pkg::CHAR_QUOTE) begin
               add_result(8'h00, qlu_pkg::KIND_OK);
               lit_mode = qlu_pkg::MODE_DONE;
            end else if (c == qlu_pkg::CHAR_BSLASH) begin
               lit_mode = qlu_pkg::MODE_ESC;
            end else begin
               add_result(c, qlu_pkg::KIND_BYTE);
            end
         end
         qlu_pkg::MODE_ESC: begin
            lit_mode = qlu_pkg::MODE_BODY;
            case (c)
               "t": add_result(8'h09, qlu_pkg::KIND_BYTE);
               "b": add_result(8'h08, qlu_pkg::KIND_BYTE);
               "n": add_result(8'h0a, qlu_pkg::KIND_BYTE);
               "r": add_result(8'h0d, qlu_pkg::KIND_BYTE);
               "f": add_result(8'h0c, qlu_pkg::KIND_BYTE);
               "u", "U": begin
                  digits_left = (c == "u") ? 4'd4 : 4'd8;
                  cp_acc = 32'd0;
                  lit_mode = qlu_pkg::MODE_HEX;
               end
               default: add_result(c, qlu_pkg::KIND_BYTE);
            endcase
         end
         qlu_pkg::MODE_HEX: begin
            if (h < 0) begin
               add_result(8'h00, qlu_pkg::KIND_BAD);
               lit_mode = qlu_pkg::MODE_DONE;
            end else begin
               cp_acc = {cp_acc[27:0], h[3:0]};
               digits_left = digits_left - 4'd1;
               if (digits_left == 4'd0) begin
                  add_utf8(cp_acc);
                  lit_mode = qlu_pkg::MODE_BODY;
               end
            end
         end
         default: ;
      endcase
      if (line_end) begin
         if (lit_mode != qlu_pkg::MODE_DONE) add_result(8'h00, qlu_pkg::KIND_BAD);
         lit_mode = qlu_pkg::MODE_SKIP;
         digits_left = 4'd0;
         cp_acc = 32'd0;
      end
      if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
      foreach (step_results[i]) decoded_results.insert(decoded_results.size(), step_results[i]);
   endfunction

   task report_mismatch(input string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      error_count++;
   endtask

   always @(posedge clock) begin : monitor
      lit_result_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_decode(req_tdata, req_tlast);
            bytes_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (decoded_results.size() == 0) begin
               report_mismatch($sformatf("result %h/%0d with nothing pending",
                                         rsp_tdata, rsp_tuser));
            end else begin
               want = decoded_results.pop_front();
               results_checked++;
               if (rsp_tdata !== want.data)
                  report_mismatch($sformatf("out_byte %h, expected %h", rsp_tdata, want.data));
               if (rsp_tuser !== want.kind)
                  report_mismatch($sformatf("out_kind %0d, expected %0d", rsp_tuser, want.kind));
               if (rsp_tlast !== want.last)
                  report_mismatch($sformatf("run_last %0b, expected %0b", rsp_tlast, want.last));
            end
         end
      end
   end

   // The receiver switches between steady acceptance and several stall
   // patterns, drawing a new one whenever the 7-bit phase counter wraps.
   always @(posedge clock) begin
      stall_phase <= stall_phase + 7'd1;
      if (stall_phase == 7'd0) stall_style <= 2'($urandom_range(0, 3));
      case (stall_style)
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2'd2: rsp_tready <= (stall_phase[1:0] != 2'd3);
         default: rsp_tready <= stall_phase[3];
      endcase
   end

   task send_byte(input logic [7:0] b, input logic last);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task send_line();
      foreach (line_bytes[i]) send_byte(line_bytes[i], i == line_bytes.size() - 1);
      lines_sent++;
   endtask

   task wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (decoded_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function void append_byte(logic [7:0] b);
      line_bytes.insert(line_bytes.size(), b);
   endfunction

   function automatic logic [31:0] random_code_point(int classes);
      case ($urandom_range(0, classes))
         0: return $urandom_range(0, 32'h7f);
         1: return $urandom_range(32'h80, 32'h7ff);
         2: return $urandom_range(32'h800, 32'hffff);
         3: return $urandom_range(32'h10000, 32'h10ffff);
         4: return $urandom_range(32'h110000, 32'hffffffff);
         default: return $urandom;
      endcase
   endfunction

   function void push_hex(logic [31:0] cp, int ndigits);
      logic [3:0] nib;
      for (int i = ndigits - 1; i >= 0; i--) begin
         nib = cp[4 * i +: 4];
         if (nib < 4'd10) append_byte(8'("0") + 8'(nib));
         else if ($urandom_range(0, 1) == 1) append_byte(8'("a") + 8'(nib) - 8'd10);
         else append_byte(8'("A") + 8'(nib) - 8'd10);
      end
   endfunction

   function void add_random_piece();
      logic [7:0] b;
      string esc_letters;
      int idx;
      esc_letters = "tbnrf";
      case ($urandom_range(0, 4))
         0, 1: begin
            do b = 8'($urandom_range(0, 255));
            while (b == qlu_pkg::CHAR_QUOTE || b == qlu_pkg::CHAR_BSLASH);
            append_byte(b);
         end
         2: begin
            append_byte(qlu_pkg::CHAR_BSLASH);
            idx = $urandom_range(0, 6);
            if (idx < 5) begin
               append_byte(esc_letters[idx]);
            end else begin
               do b = 8'($urandom_range(0, 255)); while (b == "u" || b == "U");
               append_byte(b);
            end
         end
         3: begin
            append_byte(qlu_pkg::CHAR_BSLASH);
            append_byte("u");
            push_hex(random_code_point(2), 4);
         end
         default: begin
            append_byte(qlu_pkg::CHAR_BSLASH);
            append_byte("U");
            push_hex(random_code_point(5), 8);
         end
      endcase
   endfunction

   // Mostly well-formed literals with random content; the rest open with a
   // bad character, carry a bad hex digit, or stop before the closing quote.
   task send_random_line();
      int shape;
      int useful;
      int ndigits;
      logic [7:0] b;
      line_bytes.delete();
      shape = $urandom_range(0, 9);
      if (shape == 0) begin
         do b = 8'($urandom_range(0, 255));
         while (b == qlu_pkg::CHAR_QUOTE || b == qlu_pkg::CHAR_SPACE || b == qlu_pkg::CHAR_TAB);
         append_byte(b);
      end else begin
         repeat ($urandom_range(0, 2))
            append_byte(($urandom_range(0, 1) == 1) ? qlu_pkg::CHAR_SPACE : qlu_pkg::CHAR_TAB);
         append_byte(qlu_pkg::CHAR_QUOTE);
         repeat ($urandom_range(0, 5)) add_random_piece();
         if (shape == 1) begin
            ndigits = $urandom_range(0, 1) ? 4 : 8;
            append_byte(qlu_pkg::CHAR_BSLASH);
            append_byte((ndigits == 4) ? "u" : "U");
            push_hex($urandom, $urandom_range(0, ndigits - 1));
            do b = 8'($urandom_range(0, 255)); while (hex_value(b) >= 0);
            append_byte(b);
         end else if (shape == 2) begin
            useful = $urandom_range(1, line_bytes.size());
            while (line_bytes.size() > useful) line_bytes.delete(line_bytes.size() - 1);
         end else begin
            append_byte(qlu_pkg::CHAR_QUOTE);
         end
      end
      if (shape != 2)
         repeat ($urandom_range(0, 2)) append_byte(8'($urandom_range(0, 255)));
      send_line();
      random_items += line_bytes.size();
   endtask

   task test_escapes();
      line_bytes = '{qlu_pkg::CHAR_SPACE, qlu_pkg::CHAR_TAB, qlu_pkg::CHAR_QUOTE, 8'h00,
                     qlu_pkg::CHAR_BSLASH, "t", qlu_pkg::CHAR_BSLASH, "b",
                     qlu_pkg::CHAR_BSLASH, "n", qlu_pkg::CHAR_BSLASH, "r",
                     qlu_pkg::CHAR_BSLASH, "f", qlu_pkg::CHAR_BSLASH, 8'hff,
                     qlu_pkg::CHAR_QUOTE, "q"};
      send_line();
      wait_for_results();
   endtask

   task test_status_cases();
      line_bytes = '{"x"};
      send_line();
      line_bytes = '{qlu_pkg::CHAR_SPACE};
      send_line();
      line_bytes = '{qlu_pkg::CHAR_QUOTE, qlu_pkg::CHAR_BSLASH};
      send_line();
      line_bytes = '{qlu_pkg::CHAR_QUOTE, qlu_pkg::CHAR_BSLASH, "u", "g"};
      send_line();
      line_bytes = '{qlu_pkg::CHAR_QUOTE, qlu_pkg::CHAR_BSLASH, "u", "1"};
      send_line();
      wait_for_results();
   endtask

   task test_code_points();
      // A value beyond the Unicode range produces no bytes, and the line then
      // ends inside the literal body.
      line_bytes = '{qlu_pkg::CHAR_QUOTE, qlu_pkg::CHAR_BSLASH, "U", "F", "F", "F", "F",
                     "f", "f", "f", "f"};
      send_line();
      // A surrogate is encoded like any other three-byte value.
      line_bytes = '{qlu_pkg::CHAR_QUOTE, qlu_pkg::CHAR_BSLASH, "u", "d", "8", "0", "0",
                     qlu_pkg::CHAR_QUOTE};
      send_line();
      wait_for_results();
   endtask

   task test_random_lines();
      bit paused;
      paused = 1'b0;
      while (random_items < 170) begin
         send_random_line();
         if (!paused && random_items >= 85) begin
            wait_for_results();
            paused = 1'b1;
         end
      end
      wait_for_results();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_escapes();
      test_status_cases();
      test_code_points();
      test_random_lines();
      if (decoded_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", decoded_results.size()));
      $display("Sent %0d lines (%0d request bytes) and checked %0d results.",
               lines_sent, bytes_taken, results_checked);
      $display("Lines covered escapes, all UTF-8 lengths, out-of-range values and each status.");
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("Timeout waiting for the block.");
      $display("Some tests failed");
      $finish;
   end

endmodule
